// ===== src/sthc_pkg.sv =====
// ---------------------------------------------------------------------------
// sthc_pkg
// Shared types and constants of the strip/time hit clusterer.
// ---------------------------------------------------------------------------
package sthc_pkg;

   localparam int STRIP_W = 7;
   localparam int TIME_W  = 14;
   localparam int SIZE_W  = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam int DEF_MAX_HITS    = 64;
   localparam int DEF_STRIP_COUNT = 128;

   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_WINDOW  = 2'd1;

   localparam logic [STRIP_W-1:0] STRIP_WINDOW_RST = 7'd2;
   localparam logic [TIME_W-1:0]  TIME_WINDOW_RST  = 14'd160;

   typedef struct packed {
      logic [STRIP_W-1:0] strip;
      logic [TIME_W-1:0]  hit_time;
      logic               last_hit;
   } req_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  cluster_size;
      logic [STRIP_W-1:0] center_strip;
      logic [STRIP_W-1:0] min_strip;
      logic [STRIP_W-1:0] max_strip;
      logic [TIME_W-1:0]  first_time;
      logic [TIME_W-1:0]  final_time;
      logic               overflowed;
      logic               last_cluster;
   } rsp_type;

   typedef struct packed {
      logic [STRIP_W-1:0] strip;
      logic [TIME_W-1:0]  hit_time;
   } hit_type;

   typedef enum logic [1:0] {
      HIT_FREE,
      HIT_QUEUED,
      HIT_DONE
   } hit_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_EMIT,
      ST_FIND,
      ST_LINK,
      ST_DIV
   } fsm_type;

endpackage

// ===== src/sthc_hit_store.sv =====
// ---------------------------------------------------------------------------
// sthc_hit_store
// Hit memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sthc_hit_store import sthc_pkg::*; #(
   parameter int DEPTH  = DEF_MAX_HITS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  hit_type           wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output hit_type           rd_data
);

   hit_type mem [DEPTH];
   hit_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sthc_divider.sv =====
// ---------------------------------------------------------------------------
// sthc_divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sthc_divider import sthc_pkg::*; #(
   parameter int NUM_W = 13,
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    trial;

   always_comb begin
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         step_in = STEP_W'(NUM_W);
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (step_ff != '0) begin
         // shift in the next numerator bit, subtract where it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         done_in = (step_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/strip_time_hit_clusterer.sv =====
// ---------------------------------------------------------------------------
// strip_time_hit_clusterer
// Collects an event's hits in a memory and, on the last hit, walks the
// memory to form connected clusters of linked hits, one result each.
// ---------------------------------------------------------------------------
//
//   channel | direction | ports                         | transfer when
//   --------+-----------+-------------------------------+-------------------
//   req     | in        | req_valid, req_stall, req_data| valid and not stall
//   rsp     | out       | rsp_valid, rsp_stall, rsp_data| valid and not stall
//   csr     | in        | csr_write, csr_index, csr_data| csr_write high
//
// Hits load at one per cycle while no event is being clustered.
// A cluster costs a seed search, then per hit a search to find it queued
// and a link scan, then a closing queue search, a divide and an emit; one
// more seed search closes the event. Each scan streams both memories.
// Reset is synchronous; a stalled result holds while the next search runs on.
// ---------------------------------------------------------------------------
module strip_time_hit_clusterer import sthc_pkg::*; #(
   parameter int MAX_HITS    = DEF_MAX_HITS,
   parameter int STRIP_COUNT = DEF_STRIP_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int CNT_W  = $clog2(MAX_HITS + 1);
   localparam int SUM_W  = $clog2(MAX_HITS * STRIP_COUNT);
   localparam int KEY_W  = STRIP_W + TIME_W;

   fsm_type state_ff, state_in;

   logic [CNT_W-1:0]  hit_count_ff, hit_count_in;
   logic              overflow_ff, overflow_in;
   logic [STRIP_W-1:0] strip_window_ff;
   logic [TIME_W-1:0]  time_window_ff;

   // per-hit walk state, one synchronous memory read beside the hit memory
   hit_state_type     hit_state_mem [MAX_HITS];
   hit_state_type     state_rd_ff;
   logic              st_we;
   logic [ADDR_W-1:0] st_waddr;
   hit_state_type     st_wdata;

   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [ADDR_W-1:0] pend_idx_ff, pend_idx_in;
   logic              found_ff, found_in;
   logic [KEY_W-1:0]  best_key_ff, best_key_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic              have_prev_ff, have_prev_in;
   logic              last_flag_ff, last_flag_in;

   logic [STRIP_W-1:0] cur_strip_ff, cur_strip_in;
   logic [TIME_W-1:0]  cur_time_ff, cur_time_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [STRIP_W-1:0] smin_ff, smin_in, smax_ff, smax_in;
   logic [TIME_W-1:0]  tmin_ff, tmin_in, tmax_ff, tmax_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_raddr;
   hit_type           mem_wdata, mem_rdata;

   logic              div_start, div_done;
   logic [SUM_W-1:0]  div_numer, div_quot;

   logic              req_xfer, in_range, scan_more, scan_end, out_free;
   logic [KEY_W-1:0]  rd_key;
   logic [STRIP_W-1:0] ds;
   logic [TIME_W-1:0]  dt;
   logic              link_hit;

   sthc_hit_store #(.DEPTH(MAX_HITS), .ADDR_W(ADDR_W)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (hit_count_ff[ADDR_W-1:0]),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // ceiling of the mean: (sum + size - 1) / size
   assign div_numer = sum_ff + SUM_W'(cnt_ff) - SUM_W'(1);

   sthc_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (cnt_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Both memories are read at the scan address, so the walk state and the
   // hit arrive together. A scan writes an entry only after reading it and
   // reads each entry once, so no read meets a write to the same entry.
   always_ff @(posedge clock) begin
      if (st_we) begin
         hit_state_mem[st_waddr] <= st_wdata;
      end
      state_rd_ff <= hit_state_mem[mem_raddr];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign in_range  = (int'(req_data.strip) < STRIP_COUNT);
   assign mem_wdata = '{strip: req_data.strip, hit_time: req_data.hit_time};
   assign mem_raddr = scan_ff[ADDR_W-1:0];

   assign scan_more = (scan_ff < hit_count_ff);
   assign scan_end  = !scan_more && !pend_vld_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_key    = {mem_rdata.strip, mem_rdata.hit_time};

   // link test of the hit just read against the hit being expanded
   assign ds = (mem_rdata.strip > cur_strip_ff) ? mem_rdata.strip - cur_strip_ff
                                                : cur_strip_ff - mem_rdata.strip;
   assign dt = (mem_rdata.hit_time > cur_time_ff) ? mem_rdata.hit_time - cur_time_ff
                                                  : cur_time_ff - mem_rdata.hit_time;
   assign link_hit = (ds < strip_window_ff) && (dt < time_window_ff);

   always_comb begin
      state_in     = state_ff;
      hit_count_in = hit_count_ff;
      overflow_in  = overflow_ff;
      scan_in      = scan_ff;
      pend_vld_in  = 1'b0;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      best_key_in  = best_key_ff;
      best_idx_in  = best_idx_ff;
      have_prev_in = have_prev_ff;
      last_flag_in = last_flag_ff;
      cur_strip_in = cur_strip_ff;
      cur_time_in  = cur_time_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      smin_in      = smin_ff;
      smax_in      = smax_ff;
      tmin_in      = tmin_ff;
      tmax_in      = tmax_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      st_we        = 1'b0;
      st_waddr     = pend_idx_ff;
      st_wdata     = HIT_FREE;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (in_range) begin
                  if (hit_count_ff < CNT_W'(MAX_HITS)) begin
                     // a freshly stored hit starts out free
                     mem_we       = 1'b1;
                     st_we        = 1'b1;
                     st_waddr     = hit_count_ff[ADDR_W-1:0];
                     st_wdata     = HIT_FREE;
                     hit_count_in = hit_count_ff + 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               if (req_data.last_hit) begin
                  state_in     = ST_SEED;
                  scan_in      = '0;
                  found_in     = 1'b0;
                  have_prev_in = 1'b0;
               end
            end
         end

         ST_SEED: begin
            // find the free hit with the lowest (strip, time)
            if (scan_more) begin
               scan_in     = scan_ff + 1'b1;
               pend_vld_in = 1'b1;
               pend_idx_in = scan_ff[ADDR_W-1:0];
            end
            if (pend_vld_ff && state_rd_ff == HIT_FREE &&
                (!found_ff || rd_key < best_key_ff)) begin
               found_in    = 1'b1;
               best_key_in = rd_key;
               best_idx_in = pend_idx_ff;
            end
            if (scan_end) begin
               if (have_prev_ff) begin
                  last_flag_in = !found_ff;
                  state_in     = ST_EMIT;
               end else if (found_ff) begin
                  st_we    = 1'b1;
                  st_waddr = best_idx_ff;
                  st_wdata = HIT_QUEUED;
                  cnt_in   = CNT_W'(1);
                  sum_in   = SUM_W'(best_key_ff[KEY_W-1:TIME_W]);
                  smin_in  = best_key_ff[KEY_W-1:TIME_W];
                  smax_in  = best_key_ff[KEY_W-1:TIME_W];
                  tmin_in  = best_key_ff[TIME_W-1:0];
                  tmax_in  = best_key_ff[TIME_W-1:0];
                  scan_in  = '0;
                  state_in = ST_FIND;
               end else begin
                  hit_count_in = '0;
                  overflow_in  = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.cluster_size = SIZE_W'(cnt_ff);
               rsp_data_in.center_strip = STRIP_W'(div_quot);
               rsp_data_in.min_strip    = smin_ff;
               rsp_data_in.max_strip    = smax_ff;
               rsp_data_in.first_time   = tmin_ff;
               rsp_data_in.final_time   = tmax_ff;
               rsp_data_in.overflowed   = overflow_ff;
               rsp_data_in.last_cluster = last_flag_ff;
               if (last_flag_ff) begin
                  // event closed: drop the stored hits
                  hit_count_in = '0;
                  overflow_in  = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  st_we    = 1'b1;
                  st_waddr = best_idx_ff;
                  st_wdata = HIT_QUEUED;
                  cnt_in   = CNT_W'(1);
                  sum_in   = SUM_W'(best_key_ff[KEY_W-1:TIME_W]);
                  smin_in  = best_key_ff[KEY_W-1:TIME_W];
                  smax_in  = best_key_ff[KEY_W-1:TIME_W];
                  tmin_in  = best_key_ff[TIME_W-1:0];
                  tmax_in  = best_key_ff[TIME_W-1:0];
                  scan_in  = '0;
                  state_in = ST_FIND;
               end
            end
         end

         ST_FIND: begin
            // look for a queued hit still to expand; its hit is read alongside
            if (pend_vld_ff && state_rd_ff == HIT_QUEUED) begin
               st_we        = 1'b1;
               st_waddr     = pend_idx_ff;
               st_wdata     = HIT_DONE;
               cur_strip_in = mem_rdata.strip;
               cur_time_in  = mem_rdata.hit_time;
               scan_in      = '0;
               state_in     = ST_LINK;
            end else if (scan_more) begin
               scan_in     = scan_ff + 1'b1;
               pend_vld_in = 1'b1;
               pend_idx_in = scan_ff[ADDR_W-1:0];
            end else if (!pend_vld_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end

         ST_LINK: begin
            if (scan_more) begin
               scan_in     = scan_ff + 1'b1;
               pend_vld_in = 1'b1;
               pend_idx_in = scan_ff[ADDR_W-1:0];
            end
            if (pend_vld_ff && state_rd_ff == HIT_FREE && link_hit) begin
               st_we    = 1'b1;
               st_waddr = pend_idx_ff;
               st_wdata = HIT_QUEUED;
               cnt_in = cnt_ff + 1'b1;
               sum_in = sum_ff + SUM_W'(mem_rdata.strip);
               if (mem_rdata.strip < smin_ff)    smin_in = mem_rdata.strip;
               if (mem_rdata.strip > smax_ff)    smax_in = mem_rdata.strip;
               if (mem_rdata.hit_time < tmin_ff) tmin_in = mem_rdata.hit_time;
               if (mem_rdata.hit_time > tmax_ff) tmax_in = mem_rdata.hit_time;
            end
            if (scan_end) begin
               scan_in  = '0;
               state_in = ST_FIND;
            end
         end

         ST_DIV: begin
            if (div_done) begin
               have_prev_in = 1'b1;
               found_in     = 1'b0;
               scan_in      = '0;
               state_in     = ST_SEED;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         hit_count_ff    <= '0;
         overflow_ff     <= 1'b0;
         strip_window_ff <= STRIP_WINDOW_RST;
         time_window_ff  <= TIME_WINDOW_RST;
         pend_vld_ff     <= 1'b0;
         have_prev_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_count_ff <= hit_count_in;
         overflow_ff  <= overflow_in;
         pend_vld_ff  <= pend_vld_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_STRIP_WINDOW: strip_window_ff <= csr_data[STRIP_W-1:0];
               CSR_TIME_WINDOW:  time_window_ff  <= csr_data[TIME_W-1:0];
               default: ;
            endcase
         end
      end
      scan_ff      <= scan_in;
      pend_idx_ff  <= pend_idx_in;
      found_ff     <= found_in;
      best_key_ff  <= best_key_in;
      best_idx_ff  <= best_idx_in;
      last_flag_ff <= last_flag_in;
      cur_strip_ff <= cur_strip_in;
      cur_time_ff  <= cur_time_in;
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      smin_ff      <= smin_in;
      smax_ff      <= smax_in;
      tmin_ff      <= tmin_in;
      tmax_ff      <= tmax_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/sthc_checker.sv =====
// ---------------------------------------------------------------------------
// sthc_checker
// Port-level checks of the hit clusterer, bound to the top level.
// ---------------------------------------------------------------------------
module sthc_checker import sthc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cluster_size != '0)
      else $error("empty cluster reported");

   a_center: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.min_strip <= rsp_data.center_strip &&
                    rsp_data.center_strip <= rsp_data.max_strip)
      else $error("centre strip outside cluster span");

   a_times: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.first_time <= rsp_data.final_time)
      else $error("first time after final time");

   // a result is only raised by a cycle in which hits were held off
   a_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("hit taken while clusters are being sent");

endmodule

bind strip_time_hit_clusterer sthc_checker u_sthc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strip/time hit clusterer. Events of hits are
// sent with random gaps, the expected clusters are worked out by a
// connected-component predictor in the scoreboard, and every result
// transfer is compared field by field. The link windows are changed
// between events, including zero and full-scale windows.
// ---------------------------------------------------------------------------
import sthc_pkg::*;

class cluster_scoreboard;
   hit_type            event_hits[$];
   bit                 event_overflow;
   logic [STRIP_W-1:0] strip_window;
   logic [TIME_W-1:0]  time_window;
   rsp_type            expected_clusters[$];
   int                 errors;

   function new();
      strip_window = STRIP_WINDOW_RST;
      time_window  = TIME_WINDOW_RST;
      errors       = 0;
   endfunction

   function void write_window(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_STRIP_WINDOW) begin
         strip_window = data[STRIP_W-1:0];
      end else if (idx == CSR_TIME_WINDOW) begin
         time_window = data[TIME_W-1:0];
      end
   endfunction

   function bit hits_linked(hit_type a, hit_type b);
      int ds;
      int dt;
      ds = int'(a.strip) - int'(b.strip);
      dt = int'(a.hit_time) - int'(b.hit_time);
      if (ds < 0) ds = -ds;
      if (dt < 0) dt = -dt;
      return (ds < int'(strip_window)) && (dt < int'(time_window));
   endfunction

   // Group the stored hits into connected clusters, lowest (strip, time) first.
   function void form_clusters();
      int      order[DEF_MAX_HITS];
      bit      taken[DEF_MAX_HITS];
      int      walk[$];
      int      n;
      int      j;
      int      v;
      int      cur;
      int      head;
      int      sum;
      rsp_type r;
      n = event_hits.size();
      for (int k = 0; k < n; k++) begin
         v = k;
         j = k;
         while (j > 0 && {event_hits[order[j-1]].strip, event_hits[order[j-1]].hit_time}
                         > {event_hits[v].strip, event_hits[v].hit_time}) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = v;
         taken[k] = 0;
      end
      for (int k = 0; k < n; k++) begin
         if (!taken[order[k]]) begin
            walk.delete();
            taken[order[k]] = 1;
            walk.insert(walk.size(), order[k]);
            head = 0;
            while (head < walk.size()) begin
               cur = walk[head];
               head++;
               for (int m = 0; m < n; m++) begin
                  if (!taken[m] && hits_linked(event_hits[cur], event_hits[m])) begin
                     taken[m] = 1;
                     walk.insert(walk.size(), m);
                  end
               end
            end
            sum          = 0;
            r.min_strip  = event_hits[order[k]].strip;
            r.max_strip  = event_hits[order[k]].strip;
            r.first_time = event_hits[order[k]].hit_time;
            r.final_time = event_hits[order[k]].hit_time;
            foreach (walk[q]) begin
               sum += event_hits[walk[q]].strip;
               if (event_hits[walk[q]].strip < r.min_strip) r.min_strip = event_hits[walk[q]].strip;
               if (event_hits[walk[q]].strip > r.max_strip) r.max_strip = event_hits[walk[q]].strip;
               if (event_hits[walk[q]].hit_time < r.first_time)
                  r.first_time = event_hits[walk[q]].hit_time;
               if (event_hits[walk[q]].hit_time > r.final_time)
                  r.final_time = event_hits[walk[q]].hit_time;
            end
            r.cluster_size = SIZE_W'(walk.size());
            r.center_strip = STRIP_W'((sum + walk.size() - 1) / walk.size());
            r.overflowed   = event_overflow;
            r.last_cluster = 0;
            expected_clusters.insert(expected_clusters.size(), r);
         end
      end
      if (n > 0) expected_clusters[expected_clusters.size()-1].last_cluster = 1;
   endfunction

   function void note_hit(req_type h);
      hit_type s;
      s.strip    = h.strip;
      s.hit_time = h.hit_time;
      if (event_hits.size() < DEF_MAX_HITS) begin
         event_hits.insert(event_hits.size(), s);
      end else begin
         event_overflow = 1;
      end
      if (h.last_hit) begin
         form_clusters();
         event_hits.delete();
         event_overflow = 0;
      end
   endfunction

   function void field_mismatch(string field, int unsigned exp_v, int unsigned act_v);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      errors++;
   endfunction

   function void check_cluster(rsp_type got);
      rsp_type e;
      if (expected_clusters.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      e = expected_clusters.pop_front();
      if (got.cluster_size !== e.cluster_size)
         field_mismatch("cluster_size", e.cluster_size, got.cluster_size);
      if (got.center_strip !== e.center_strip)
         field_mismatch("center_strip", e.center_strip, got.center_strip);
      if (got.min_strip !== e.min_strip) field_mismatch("min_strip", e.min_strip, got.min_strip);
      if (got.max_strip !== e.max_strip) field_mismatch("max_strip", e.max_strip, got.max_strip);
      if (got.first_time !== e.first_time)
         field_mismatch("first_time", e.first_time, got.first_time);
      if (got.final_time !== e.final_time)
         field_mismatch("final_time", e.final_time, got.final_time);
      if (got.overflowed !== e.overflowed)
         field_mismatch("overflowed", e.overflowed, got.overflowed);
      if (got.last_cluster !== e.last_cluster)
         field_mismatch("last_cluster", e.last_cluster, got.last_cluster);
   endfunction
endclass

module tb_top;

   localparam int WATCHDOG_LIMIT = 100000;
   localparam int SETTLE_CYCLES  = 300;
   localparam int RANDOM_HITS    = 270;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1;
   rsp_type               rsp_data;
   logic                  csr_write = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   cluster_scoreboard sb = new();
   int  watchdog_count = 0;
   int  results_seen = 0;
   bit  sender_quiet = 0;
   bit  receiver_quiet = 0;
   bit  held_off = 0;

   always #10 clock = ~clock;

   strip_time_hit_clusterer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Offer one hit after a random gap and hold it until the transfer.
   task automatic send_hit(logic [STRIP_W-1:0] strip, logic [TIME_W-1:0] t, bit last);
      req_type h;
      int      gap;
      h.strip    = strip;
      h.hit_time = t;
      h.last_hit = last;
      gap = sender_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= h;
      do @(posedge clock); while (req_stall);
      sb.note_hit(h);
   endtask

   // Drain outstanding clusters, then let the block finish its seed search.
   task automatic wait_idle();
      req_valid <= 0;
      while (sb.expected_clusters.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_windows(logic [CSR_DATA_W-1:0] sw, logic [CSR_DATA_W-1:0] tw);
      logic [CSR_IDX_W-1:0]  junk_idx;
      logic [CSR_DATA_W-1:0] junk_data;
      junk_idx  = CSR_IDX_W'($urandom_range(2, 3));
      junk_data = CSR_DATA_W'($urandom);
      csr_write <= 1; csr_index <= CSR_STRIP_WINDOW; csr_data <= sw;
      @(posedge clock);
      sb.write_window(CSR_STRIP_WINDOW, sw);
      csr_index <= CSR_TIME_WINDOW; csr_data <= tw;
      @(posedge clock);
      sb.write_window(CSR_TIME_WINDOW, tw);
      // an index past the register list must leave both windows alone
      csr_index <= junk_idx; csr_data <= junk_data;
      @(posedge clock);
      sb.write_window(junk_idx, junk_data);
      csr_write <= 0;
      @(posedge clock);
   endtask

   // Random event: mostly hits bunched round a seed so that links form.
   task automatic random_event(int n_hits);
      logic [STRIP_W-1:0] base_s;
      logic [TIME_W-1:0]  base_t;
      int                 spread;
      base_s = STRIP_W'($urandom);
      base_t = TIME_W'($urandom);
      spread = (sb.time_window == 0) ? 64 : 3 * int'(sb.time_window);
      sender_quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n_hits; k++) begin
         if ($urandom_range(0, 4) != 0) begin
            send_hit(STRIP_W'(base_s + $urandom_range(0, 6)),
                     TIME_W'(base_t + $urandom_range(0, spread)), k == n_hits - 1);
         end else begin
            send_hit(STRIP_W'($urandom), TIME_W'($urandom), k == n_hits - 1);
         end
      end
   endtask

   // Result side: random stall per transfer, one long hold-off.
   initial begin
      int stall_cycles;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 7) == 0) receiver_quiet = !receiver_quiet;
         stall_cycles = receiver_quiet ? 0 : $urandom_range(0, 3);
         if (results_seen == 20 && !held_off) begin
            held_off     = 1;
            stall_cycles = 600;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_cluster(rsp_data);
         results_seen++;
      end
   end

   // Abort when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         watchdog_count <= 0;
      end else if (watchdog_count >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         watchdog_count <= watchdog_count + 1;
      end
   end

   initial begin
      int sent;
      int phase;
      int n;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset windows: extremes of the fields, a transitive chain, ceiling mean
      send_hit(0, 0, 1);
      send_hit(127, 16383, 1);
      send_hit(10, 100, 0);
      send_hit(11, 200, 0);
      send_hit(12, 300, 0);
      send_hit(10, 100, 0);
      send_hit(50, 5000, 0);
      send_hit(20, 16383, 0);
      send_hit(21, 16300, 1);
      send_hit(3, 0, 0);
      send_hit(4, 0, 1);
      wait_idle();

      // zero windows: duplicates stay apart
      set_windows(0, 0);
      send_hit(5, 5, 0);
      send_hit(5, 5, 0);
      send_hit(6, 6, 1);
      wait_idle();

      // full-scale windows
      set_windows(127, 16383);
      send_hit(0, 0, 0);
      send_hit(127, 16382, 0);
      send_hit(126, 0, 1);
      wait_idle();

      // unit windows: only exact duplicates link
      set_windows(1, 1);
      send_hit(7, 7, 0);
      send_hit(7, 7, 0);
      send_hit(8, 7, 1);
      wait_idle();

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_HITS) begin
         case (phase % 5)
            0: begin
               set_windows(CSR_DATA_W'($urandom_range(1, 8)),
                           CSR_DATA_W'($urandom_range(1, 800)));
            end
            1: begin
               set_windows(0, CSR_DATA_W'($urandom_range(0, 16383)));
            end
            2: begin
               set_windows(127, 16383);
            end
            default: begin
               set_windows(CSR_DATA_W'($urandom_range(0, 127)), CSR_DATA_W'($urandom));
            end
         endcase
         for (int e = 0; e < 4; e++) begin
            // one event runs past the store capacity
            n = (phase == 1 && e == 0) ? $urandom_range(65, 70) : $urandom_range(1, 12);
            random_event(n);
            sent += n;
         end
         wait_idle();
         phase++;
      end

      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
